@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ade_pkg.sv @@
// ----------------------------------------------------------------------------
// ade_pkg
// Types and constants for the ARM data-processing instruction encoder.
// ----------------------------------------------------------------------------
package ade_pkg;

  localparam int IMM_BITS   = 8;            // width of the rotated immediate
  localparam int WORD_BITS  = 32;
  localparam int ROT_COUNT  = 16;           // rotate counts 0..15, step of 2 bits
  localparam int ROT_W      = $clog2(ROT_COUNT);

  // Operand kinds
  localparam logic [1:0] KIND_IMM     = 2'd0;
  localparam logic [1:0] KIND_REG_IMM = 2'd1;
  localparam logic [1:0] KIND_REG_REG = 2'd2;
  localparam logic [1:0] KIND_UNDEF   = 2'd3;

  // Compare and test opcodes always set flags
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_CMN = 4'd11;

  typedef struct packed {
    logic [3:0]  cond;
    logic [3:0]  opcode;
    logic        set_flags;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic [1:0]  operand_kind;
    logic [31:0] immediate_value;
    logic [1:0]  shift_type;
    logic [4:0]  shift_amount;
    logic [3:0]  shift_register;
    logic [3:0]  rm;
  } in_t;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic        status;
  } out_t;

endpackage

@@ rtl/arm_data_processing_encoder.sv @@
// ----------------------------------------------------------------------------
// arm_data_processing_encoder
// Assembles one A32 data-processing instruction word per transfer.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_valid / in_stall   | ade_pkg::in_t
//   out_    | out | out_valid / out_stall | ade_pkg::out_t
//
// One instruction per cycle sustained while out_stall is low; each item passes through
// the input register, then the result register. The encode stage is the 16-way
// rotate-and-compare immediate search with a priority pick of the smallest count.
// Reset (rst_n low, synchronous) empties both stages.
// in_stall rises only when both stages hold an item and out_stall is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arm_data_processing_encoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ade_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ade_pkg::out_t out_data
);

  import ade_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  in_t                 s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r;
  out_t                enc_nxt;

  logic                s1_load;
  logic                s2_load;

  logic [63:0]         rot_dbl;
  logic                imm_fit;
  logic [ROT_W-1:0]    imm_rot;
  logic [IMM_BITS-1:0] imm_byte;
  logic                sbit;
  logic                ibit;
  logic [11:0]         op2;

  // Flow control: each stage loads when empty or when its successor moves
  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  assign s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
  assign out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_load) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && s2_load) begin
      out_data_r <= enc_nxt;
    end
  end

  // Immediate search: smallest rotate count whose left rotation fits 8 bits
  always_comb begin
    imm_fit  = 1'b0;
    imm_rot  = '0;
    imm_byte = '0;
    rot_dbl  = '0;
    for (int i = ROT_COUNT - 1; i >= 0; i--) begin
      rot_dbl = {s1_data_r.immediate_value, s1_data_r.immediate_value} << (2 * i);
      if (rot_dbl[63:WORD_BITS+IMM_BITS] == '0) begin
        imm_fit  = 1'b1;
        imm_rot  = ROT_W'(i);
        imm_byte = rot_dbl[WORD_BITS +: IMM_BITS];
      end
    end
  end

  always_comb begin
    sbit = s1_data_r.set_flags;
    if (s1_data_r.opcode == OP_TST || s1_data_r.opcode == OP_TEQ ||
        s1_data_r.opcode == OP_CMP || s1_data_r.opcode == OP_CMN) begin
      sbit = 1'b1;
    end

    ibit = 1'b0;
    op2  = '0;
    unique case (s1_data_r.operand_kind) inside
      KIND_IMM: begin
        ibit = 1'b1;
        op2  = imm_fit ? {imm_rot, imm_byte} : 12'd0;
      end
      KIND_REG_IMM: begin
        op2 = {s1_data_r.shift_amount, s1_data_r.shift_type, 1'b0, s1_data_r.rm};
      end
      // undefined kind decodes as register-shifted-by-register
      KIND_REG_REG, KIND_UNDEF: begin
        op2 = {s1_data_r.shift_register, 1'b0, s1_data_r.shift_type, 1'b1,
               s1_data_r.rm};
      end
      default: begin
        op2 = '0;
      end
    endcase

    enc_nxt.status = ibit && !imm_fit;
    if (enc_nxt.status) begin
      enc_nxt.instruction_word = '0;
    end else begin
      enc_nxt.instruction_word = {s1_data_r.cond, 2'b00, ibit, s1_data_r.opcode, sbit,
                                  s1_data_r.rn, s1_data_r.rd, op2};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_err_word_zero, clk, rst_n, out_valid_r && out_data_r.status, out_data_r.instruction_word == '0)
  `ASSERT_IMPL(a_ok_class_bits, clk, rst_n, out_valid_r && !out_data_r.status, out_data_r.instruction_word[27:26] == 2'b00)
  `ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r && out_stall)
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, s1_valid_r)
  `ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_valid_r && !out_valid_r, out_valid_r)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the data-processing encoder against a local encode function: every
// accepted instruction queues its expected word and status, and each result
// transfer is compared field by field. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module testbench;
  import ade_pkg::*;

  localparam int STALL_LIMIT = 1000;    // cycles with no transfer before giving up
  localparam int BUSY_PCT    = 34;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  out_t encoded_q[$];
  int   err_count;
  int   send_gap_pct;
  int   recv_stall_pct;

  arm_data_processing_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Smallest rotate count r such that imm rotated left by 2r fits in 8 bits.
  function automatic out_t encode_dp(input in_t it);
    out_t        res;
    logic [63:0] dbl;
    logic [31:0] rot;
    logic [11:0] op2;
    logic        sbit;
    logic        ibit;
    logic        bad;
    logic        found;
    op2   = '0;
    ibit  = 1'b0;
    bad   = 1'b0;
    found = 1'b0;
    sbit  = it.set_flags;
    if (it.opcode >= OP_TST && it.opcode <= OP_CMN) sbit = 1'b1;
    if (it.operand_kind == KIND_IMM) begin
      ibit = 1'b1;
      for (int r = 0; r < ROT_COUNT; r++) begin
        dbl = {it.immediate_value, it.immediate_value} << (2 * r);
        rot = dbl[63:32];
        if (!found && rot < (32'd1 << IMM_BITS)) begin
          found = 1'b1;
          op2   = {r[3:0], rot[7:0]};
        end
      end
      bad = !found;
    end else if (it.operand_kind == KIND_REG_IMM) begin
      op2 = {it.shift_amount, it.shift_type, 1'b0, it.rm};
    end else begin
      // undefined kind decodes as register-shifted-by-register
      op2 = {it.shift_register, 1'b0, it.shift_type, 1'b1, it.rm};
    end
    res.status = bad;
    if (bad) res.instruction_word = '0;
    else res.instruction_word = {it.cond, 2'b00, ibit, it.opcode, sbit, it.rn, it.rd, op2};
    return res;
  endfunction

  function automatic in_t rand_instr();
    in_t         it;
    logic [7:0]  base;
    logic [63:0] dbl;
    int          sel;
    it.cond           = 4'($urandom_range(15));
    it.opcode         = 4'($urandom_range(15));
    it.set_flags      = 1'($urandom_range(1));
    it.rn             = 4'($urandom_range(15));
    it.rd             = 4'($urandom_range(15));
    it.shift_type     = 2'($urandom_range(3));
    it.shift_amount   = 5'($urandom_range(31));
    it.shift_register = 4'($urandom_range(15));
    it.rm             = 4'($urandom_range(15));
    sel = $urandom_range(9);
    if (sel < 5) it.operand_kind = KIND_IMM;
    else if (sel < 7) it.operand_kind = KIND_REG_IMM;
    else if (sel < 9) it.operand_kind = KIND_REG_REG;
    else it.operand_kind = KIND_UNDEF;
    sel  = $urandom_range(9);
    base = 8'($urandom_range(255));
    if (sel < 6) begin
      // encodable: 8-bit value rotated right by an even count
      dbl = {24'd0, base, 24'd0, base} >> (2 * $urandom_range(15));
      it.immediate_value = dbl[31:0];
    end else if (sel < 8) begin
      it.immediate_value = $urandom;
    end else if (sel < 9) begin
      it.immediate_value = {24'd0, base} << $urandom_range(31);
    end else begin
      it.immediate_value = (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
    end
    return it;
  endfunction

  task automatic send_instr(input in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encoded_q = {encoded_q, encode_dp(it)};
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    in_t         it;
    logic [31:0] imm_list [16];
    imm_list = '{32'h0000_0000, 32'h0000_00FF, 32'h0000_0100, 32'h0000_0102,
                 32'hF000_000F, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h0000_03FC,
                 32'h8000_0000, 32'h0000_01FE, 32'hC000_003F, 32'h0000_0101,
                 32'h000F_F000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hAB00_0000};
    // every opcode and condition, with an immediate operand
    for (int op = 0; op < 16; op++) begin
      it                 = '0;
      it.cond            = 4'(op);
      it.opcode          = 4'(op);
      it.set_flags       = op[2];
      it.rn              = 4'(op);
      it.rd              = 4'(15 - op);
      it.operand_kind    = KIND_IMM;
      it.immediate_value = imm_list[op];
      it.shift_type      = op[1:0];
      it.shift_amount    = 5'(op * 2);
      it.shift_register  = 4'(op);
      it.rm              = 4'(15 - op);
      send_instr(it);
    end
    // register forms with all-ones and all-zeros fields
    it = '1;
    it.operand_kind = KIND_REG_IMM;
    send_instr(it);
    it = '0;
    it.operand_kind = KIND_REG_IMM;
    send_instr(it);
    it = '1;
    it.operand_kind = KIND_REG_REG;
    send_instr(it);
    it = '0;
    it.operand_kind = KIND_REG_REG;
    it.opcode       = OP_CMP;
    send_instr(it);
    it = '1;
    it.operand_kind = KIND_UNDEF;
    it.opcode       = OP_TST;
    it.set_flags    = 1'b0;
    send_instr(it);
  endtask

  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) send_instr(rand_instr());
  endtask

  task automatic test_back_to_back(input int count);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < count; i++) send_instr(rand_instr());
    send_gap_pct   = BUSY_PCT;
    recv_stall_pct = BUSY_PCT;
  endtask

  task automatic test_drained_bursts(input int bursts, input int burst_len);
    for (int b = 0; b < bursts; b++) begin
      for (int i = 0; i < burst_len; i++) send_instr(rand_instr());
      hold_until_drained();
    end
  endtask

  // receiver: random stall, driven at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (encoded_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual word %h status %b",
                 $time, out_data.instruction_word, out_data.status);
        err_count++;
      end else begin
        exp_res = encoded_q.pop_front();
        if (out_data.instruction_word !== exp_res.instruction_word) begin
          $display("%0t: instruction_word mismatch: expected %h, actual %h",
                   $time, exp_res.instruction_word, out_data.instruction_word);
          err_count++;
        end
        if (out_data.status !== exp_res.status) begin
          $display("%0t: status mismatch: expected %b, actual %b",
                   $time, exp_res.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    err_count      = 0;
    send_gap_pct   = BUSY_PCT;
    recv_stall_pct = BUSY_PCT;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_stream(1000);
    test_back_to_back(300);
    test_drained_bursts(10, 50);

    @(negedge clk);
    in_valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ade_pkg.sv
rtl/arm_data_processing_encoder.sv
tb/testbench.sv
